>>> rtl/counting_semaphore_bank_assert.svh
// ----------------------------------------------------------------------------
// counting semaphore bank assertion macros
// concurrent assertion wrappers; empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_BANK_ASSERT_SVH
`define COUNTING_SEMAPHORE_BANK_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define CSB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// expression must never be true outside reset
`define CSB_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`else

`define CSB_ASSERT(label, clk, rst, prop, msg)
`define CSB_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> rtl/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// shared types and constants of the counting semaphore bank
// ----------------------------------------------------------------------------
`default_nettype none

package csb_pkg;

   // free-slot search width per cycle
   localparam int SCAN_W = 16;

   // count saturation value
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // request kinds
   typedef enum logic [1:0] {
      KIND_CREATE = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_WAIT   = 2'd2,
      KIND_SIGNAL = 2'd3
   } kind_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BAD_ID  = 3'd1,
      ST_NO_SLOT = 3'd2,
      ST_WAITERS = 3'd3,
      ST_BLOCKED = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_SCAN   = 2'd1,
      FSM_LOOKUP = 2'd2,
      FSM_POP    = 2'd3
   } fsm_state_type;

   // request beat
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  sem_id;
      logic [15:0] init_value;
      logic [5:0]  caller_pid;
   } req_payload_type;

   // result beat
   typedef struct packed {
      status_type  status;
      logic [3:0]  result_sem_id;
      logic        woken_valid;
      logic [5:0]  woken_pid;
      logic [15:0] count_after;
   } rsp_payload_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic scan_step;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic req_create;
      logic need_pop;
      logic scan_hit;
      logic scan_last;
      logic out_free;
   } dpath_sts_type;

endpackage

`default_nettype wire

>>> rtl/csb_stream_if.sv
// ----------------------------------------------------------------------------
// csb_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
`default_nettype none

interface csb_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

>>> rtl/csb_ctrl.sv
// ----------------------------------------------------------------------------
// csb_ctrl
// request sequencer: accept, free-slot scan, record lookup, waiter pop
// ----------------------------------------------------------------------------
`default_nettype none

`include "counting_semaphore_bank_assert.svh"

module csb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  csb_pkg::dpath_sts_type sts,
   output logic                   req_ready,
   output csb_pkg::ctrl_cmd_type  cmd
);

   csb_pkg::fsm_state_type state_ff;
   csb_pkg::fsm_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csb_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csb_pkg::FSM_IDLE: begin
            if (req_valid) begin
               state_in = sts.req_create ? csb_pkg::FSM_SCAN : csb_pkg::FSM_LOOKUP;
            end
         end
         csb_pkg::FSM_SCAN: begin
            if (sts.out_free && (sts.scan_hit || sts.scan_last)) begin
               state_in = csb_pkg::FSM_IDLE;
            end
         end
         csb_pkg::FSM_LOOKUP: begin
            if (sts.need_pop) begin
               state_in = csb_pkg::FSM_POP;
            end else if (sts.out_free) begin
               state_in = csb_pkg::FSM_IDLE;
            end
         end
         csb_pkg::FSM_POP: begin
            if (sts.out_free) begin
               state_in = csb_pkg::FSM_IDLE;
            end
         end
         default: state_in = csb_pkg::FSM_IDLE;
      endcase
   end

   // commands
   always_comb begin
      req_ready     = 1'b0;
      cmd.capture   = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         csb_pkg::FSM_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         csb_pkg::FSM_SCAN: begin
            cmd.scan_step = !sts.scan_hit && !sts.scan_last;
            cmd.commit    = sts.out_free && (sts.scan_hit || sts.scan_last);
         end
         csb_pkg::FSM_LOOKUP: begin
            cmd.commit = sts.out_free && !sts.need_pop;
         end
         csb_pkg::FSM_POP: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // checks
   `CSB_ASSERT(a_commit_to_idle, clock, reset, cmd.commit |=> (state_ff == csb_pkg::FSM_IDLE), "no return to idle after commit")
   `CSB_ASSERT(a_pop_after_lookup, clock, reset, (state_ff == csb_pkg::FSM_POP) |-> ($past(state_ff) == csb_pkg::FSM_LOOKUP || $past(state_ff) == csb_pkg::FSM_POP), "pop entered without lookup")
   `CSB_ASSERT_NEVER(a_no_capture_commit, clock, reset, cmd.capture && cmd.commit, "capture and commit in one cycle")

endmodule

`default_nettype wire

>>> rtl/csb_dpath.sv
// ----------------------------------------------------------------------------
// csb_dpath
// slot records, waiter queues, free-slot scan and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "counting_semaphore_bank_assert.svh"

module csb_dpath #(
   parameter int NUM_SEMS   = 16,
   parameter int WAIT_DEPTH = 16,
   parameter int MAX_PROCS  = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  csb_pkg::ctrl_cmd_type    cmd,
   input  csb_pkg::req_payload_type req_data,
   input  logic                     rsp_ready,
   output csb_pkg::dpath_sts_type   sts,
   output logic                     rsp_valid,
   output csb_pkg::rsp_payload_type rsp_data
);

   localparam int IDX_W      = $clog2(NUM_SEMS);
   localparam int PTR_W      = $clog2(WAIT_DEPTH);
   localparam int FILL_W     = $clog2(WAIT_DEPTH + 1);
   localparam int WADDR_W    = $clog2(NUM_SEMS * WAIT_DEPTH);
   localparam int SCAN_W     = csb_pkg::SCAN_W;
   localparam int HIT_W      = $clog2(SCAN_W);
   localparam int NUM_CHUNKS = (NUM_SEMS + SCAN_W - 1) / SCAN_W;
   localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int PAD_W      = NUM_CHUNKS * SCAN_W;

   typedef struct packed {
      logic [15:0]       count;
      logic [PTR_W-1:0]  head;
      logic [PTR_W-1:0]  tail;
      logic [FILL_W-1:0] fill;
   } rec_type;

   // circular queue pointer advance
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   csb_pkg::req_payload_type req_ff;
   logic [NUM_SEMS-1:0]      in_use_ff;
   logic [NUM_SEMS-1:0]      in_use_in;
   logic [NUM_SEMS-1:0]      rec_valid_ff;
   logic [NUM_SEMS-1:0]      rec_valid_in;
   rec_type                  rec_mem [NUM_SEMS];
   rec_type                  rec_rd_ff;
   logic [5:0]               wait_mem [NUM_SEMS * WAIT_DEPTH];
   logic [5:0]               wait_rd_ff;
   logic [CHUNK_W-1:0]       scan_ff;
   logic [CHUNK_W-1:0]       scan_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   csb_pkg::rsp_payload_type rsp_ff;
   csb_pkg::rsp_payload_type rsp_in;

   logic [IDX_W-1:0]   sid_idx;
   logic [IDX_W-1:0]   rec_rd_addr;
   logic               sid_ok;
   rec_type            rec_q;
   logic [WADDR_W-1:0] wait_raddr;
   logic [PAD_W-1:0]   busy_pad;
   logic [SCAN_W-1:0]  busy_chunk;
   logic               scan_hit;
   logic [HIT_W-1:0]   hit_pos;
   logic [IDX_W-1:0]   new_slot;
   logic [15:0]        count_inc;

   logic               rec_we;
   logic [IDX_W-1:0]   rec_waddr;
   rec_type            rec_wdata;
   logic               wait_we;
   logic [WADDR_W-1:0] wait_waddr;
   logic               set_use;
   logic               clr_use;
   logic [IDX_W-1:0]   use_idx;

   // addressed slot
   assign sid_idx     = req_ff.sem_id[IDX_W-1:0];
   assign sid_ok      = ({1'b0, req_ff.sem_id} < 9'(NUM_SEMS));
   assign rec_rd_addr = cmd.capture ? req_data.sem_id[IDX_W-1:0] : sid_idx;
   assign rec_q       = (sid_ok && rec_valid_ff[sid_idx]) ? rec_rd_ff : '0;
   assign count_inc   = (rec_q.count == csb_pkg::COUNT_MAX) ? rec_q.count
                                                           : rec_q.count + 16'd1;
   assign wait_raddr  = WADDR_W'(sid_idx) * WADDR_W'(WAIT_DEPTH) + WADDR_W'(rec_q.head);

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // slot record memory
   always_ff @(posedge clock) begin
      rec_rd_ff <= rec_mem[rec_rd_addr];
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
   end

   // waiter memory
   always_ff @(posedge clock) begin
      wait_rd_ff <= wait_mem[wait_raddr];
      if (wait_we) begin
         wait_mem[wait_waddr] <= req_ff.caller_pid;
      end
   end

   // free-slot scan, one chunk per cycle, padding counts as busy
   always_comb begin
      busy_pad                = '1;
      busy_pad[NUM_SEMS-1:0]  = in_use_ff;
      busy_chunk              = busy_pad[int'(scan_ff) * SCAN_W +: SCAN_W];
      scan_hit                = 1'b0;
      hit_pos                 = '0;
      for (int j = SCAN_W - 1; j >= 0; j--) begin
         if (!busy_chunk[j]) begin
            scan_hit = 1'b1;
            hit_pos  = HIT_W'(j);
         end
      end
      new_slot = IDX_W'(int'(scan_ff) * SCAN_W + int'(hit_pos));
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.capture) begin
         scan_in = '0;
      end else if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   // operation decode and state update
   always_comb begin
      rsp_in.status        = csb_pkg::ST_OK;
      rsp_in.result_sem_id = req_ff.sem_id[3:0];
      rsp_in.woken_valid   = 1'b0;
      rsp_in.woken_pid     = '0;
      rsp_in.count_after   = '0;
      rec_we               = 1'b0;
      rec_waddr            = sid_idx;
      rec_wdata            = rec_q;
      wait_we              = 1'b0;
      wait_waddr           = WADDR_W'(sid_idx) * WADDR_W'(WAIT_DEPTH) + WADDR_W'(rec_q.tail);
      set_use              = 1'b0;
      clr_use              = 1'b0;
      use_idx              = sid_idx;
      unique case (req_ff.kind)
         csb_pkg::KIND_CREATE: begin
            rsp_in.result_sem_id = '0;
            if (scan_hit) begin
               set_use              = 1'b1;
               use_idx              = new_slot;
               rec_we               = 1'b1;
               rec_waddr            = new_slot;
               rec_wdata.count      = req_ff.init_value;
               rec_wdata.head       = '0;
               rec_wdata.tail       = '0;
               rec_wdata.fill       = '0;
               rsp_in.result_sem_id = 4'(new_slot);
               rsp_in.count_after   = req_ff.init_value;
            end else begin
               rsp_in.status = csb_pkg::ST_NO_SLOT;
            end
         end
         csb_pkg::KIND_FREE: begin
            if (!sid_ok) begin
               rsp_in.status = csb_pkg::ST_BAD_ID;
            end else if (rec_q.fill != '0) begin
               rsp_in.status      = csb_pkg::ST_WAITERS;
               rsp_in.count_after = rec_q.count;
            end else begin
               clr_use         = 1'b1;
               rec_we          = 1'b1;
               rec_wdata.count = '0;
               rec_wdata.head  = '0;
               rec_wdata.tail  = '0;
            end
         end
         csb_pkg::KIND_WAIT: begin
            if (!sid_ok) begin
               rsp_in.status = csb_pkg::ST_BAD_ID;
            end else if (rec_q.count != '0) begin
               rec_we             = 1'b1;
               rec_wdata.count    = rec_q.count - 16'd1;
               rsp_in.count_after = rec_q.count - 16'd1;
            end else if (int'(req_ff.caller_pid) >= MAX_PROCS) begin
               rsp_in.status = csb_pkg::ST_BAD_ID;
            end else if (int'(rec_q.fill) >= WAIT_DEPTH) begin
               rsp_in.status = csb_pkg::ST_FULL;
            end else begin
               wait_we        = 1'b1;
               rec_we         = 1'b1;
               rec_wdata.tail = next_ptr(rec_q.tail);
               rec_wdata.fill = rec_q.fill + 1'b1;
               rsp_in.status  = csb_pkg::ST_BLOCKED;
            end
         end
         csb_pkg::KIND_SIGNAL: begin
            if (!sid_ok) begin
               rsp_in.status = csb_pkg::ST_BAD_ID;
            end else begin
               rec_we             = 1'b1;
               rec_wdata.count    = count_inc;
               rsp_in.count_after = count_inc;
               if (rec_q.fill != '0) begin
                  rec_wdata.head     = next_ptr(rec_q.head);
                  rec_wdata.fill     = rec_q.fill - 1'b1;
                  rsp_in.woken_valid = 1'b1;
                  rsp_in.woken_pid   = wait_rd_ff;
               end
            end
         end
         default: rsp_in.status = csb_pkg::ST_OK;
      endcase
      // writes only take effect on commit
      rec_we  = rec_we && cmd.commit;
      wait_we = wait_we && cmd.commit;
   end

   // allocation and record valid flags
   always_comb begin
      in_use_in    = in_use_ff;
      rec_valid_in = rec_valid_ff;
      if (cmd.commit && set_use) begin
         in_use_in[use_idx] = 1'b1;
      end
      if (cmd.commit && clr_use) begin
         in_use_in[use_idx] = 1'b0;
      end
      if (rec_we) begin
         rec_valid_in[rec_waddr] = 1'b1;
      end
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff    <= '0;
         rec_valid_ff <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_use_ff    <= in_use_in;
         rec_valid_ff <= rec_valid_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // status to controller
   assign sts.req_create = (req_data.kind == csb_pkg::KIND_CREATE);
   assign sts.need_pop   = sid_ok && (req_ff.kind == csb_pkg::KIND_SIGNAL)
                           && (rec_q.fill != '0);
   assign sts.scan_hit   = scan_hit;
   assign sts.scan_last  = (scan_ff == CHUNK_W'(NUM_CHUNKS - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `CSB_ASSERT(a_commit_out_free, clock, reset, cmd.commit |-> (!rsp_valid_ff || rsp_ready), "result beat overwritten before taken")
   `CSB_ASSERT(a_fill_bound, clock, reset, rec_we |-> (int'(rec_wdata.fill) <= WAIT_DEPTH), "queue fill beyond depth")
   `CSB_ASSERT(a_woken_ok, clock, reset, (rsp_valid_ff && rsp_ff.woken_valid) |-> (rsp_ff.status == csb_pkg::ST_OK), "woken waiter with failing status")

endmodule

`default_nettype wire

>>> rtl/counting_semaphore_bank.sv
// Result beat is registered: a request is taken in idle and its slot record is read in lookup;
// a waking signal adds the pop state, and create uses the 16-slot-per-cycle free-slot scan instead.
// Each commits once the result register is free. Only idle takes a new request; one slot record read per request.
// The result register lets the next request in while a result beat waits to be taken.
// Reset (synchronous, active high): all slots free, counts and queues empty, no result pending.
// ----------------------------------------------------------------------------
// counting_semaphore_bank
// bank of counting semaphores with per-slot fifo queues of waiting process ids
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_bank #(
   parameter int NUM_SEMS   = 16,
   parameter int WAIT_DEPTH = 16,
   parameter int MAX_PROCS  = 64
) (
   input  logic          clock,
   input  logic          reset,
   csb_stream_if.sink    req_ch,
   csb_stream_if.source  rsp_ch
);

   csb_pkg::ctrl_cmd_type  cmd;
   csb_pkg::dpath_sts_type sts;

   // sequencer
   csb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .sts       (sts),
      .req_ready (req_ch.ready),
      .cmd       (cmd)
   );

   // records, queues and result register
   csb_dpath #(
      .NUM_SEMS   (NUM_SEMS),
      .WAIT_DEPTH (WAIT_DEPTH),
      .MAX_PROCS  (MAX_PROCS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_ch.payload),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_ch.payload)
   );

endmodule

`default_nettype wire
